// ===== hdl/spw_pkg.sv =====
// swirl point warp: shared payload types, widths, register indexes and the arctangent table
// used by the top level and by the square root, divider and rotation pipelines
// depends on nothing
package spw_pkg;

  // field and datapath widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned DIFF_W   = 33;  // point minus center
  localparam int unsigned SUM_W    = 66;  // dx*dx + dy*dy
  localparam int unsigned ROOT_W   = 33;  // integer square root of the sum
  localparam int unsigned REM_W    = 35;  // square root partial remainder
  localparam int unsigned PROD_W   = 61;  // |speed| * turn constant, plus rounding
  localparam int unsigned QUOT_W   = 32;  // turn, modulo a full turn
  localparam int unsigned CORD_W   = 52;  // rotation x and y with guard bits
  localparam int unsigned ANG_W    = 34;  // rotation residual angle
  localparam int unsigned CORDIC_N = 32;  // rotation steps
  localparam int unsigned ATAN_W   = 30;

  // 2^32 / (2*pi), rounded
  localparam logic [29:0] TURN_K    = 30'd683565276;
  // 0.999 over the rotation gain, Q0.32
  localparam logic [31:0] SCALE_Q32 = 32'd2605523365;

  // configuration register indexes
  localparam logic [1:0] CFG_CENTER_X = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [1:0] CFG_SPEED    = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [COORD_W-1:0]        handle_angle;
    logic                      last_node;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic [COORD_W-1:0]        new_handle_angle;
    logic                      last_node_out;
  } out_item_t;

  // arctangent of 2^-idx in binary angle units
  function automatic logic [ATAN_W-1:0] atan_step(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/swirl_point_warp.sv =====
// swirl point warp top level: throughput one request per cycle while in_stall_o is low;
// the square root, divider and cordic pipelines each retire one bit or one micro-rotation
// per stage; a skid register behind the output register holds one result while the output
// stalls, the pipe freezes only when it is full
// reset (async, active low) clears all valid bits and sets the center and speed to zero
// depends on spw_pkg, spw_isqrt, spw_div, spw_cordic
module swirl_point_warp import spw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned MAG_W    = 50;
  localparam int unsigned HI_W     = MAG_W;
  localparam int unsigned MID_W    = HI_W + 1;
  localparam int unsigned SCALED_W = MID_W - 16 + 1;
  localparam int unsigned SAT_W    = SCALED_W + 1;

  typedef struct packed {
    logic [PROD_W-1:0]        prod;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     neg;
    logic                     zero;
    in_item_t                 item;
  } sq_side_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     neg;
    logic                     zero;
    in_item_t                 item;
  } div_side_t;

  typedef struct packed {
    logic           zero;
    logic [31:0]    hout;
    in_item_t       item;
  } cor_side_t;

  // configuration registers
  logic signed [31:0] cx_q, cy_q, sp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      sp_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X: cx_q <= cfg_wdata_i;
        CFG_CENTER_Y: cy_q <= cfg_wdata_i;
        CFG_SPEED:    sp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // output and skid registers
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;
  logic      pipe_en;
  logic      t_valid_q;
  out_item_t t_q;

  assign pipe_en    = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // stage a: offsets, magnitudes
  logic signed [DIFF_W-1:0] dx_d, dy_d;
  logic [DIFF_W-1:0]        ax_d, ay_d;
  logic [31:0]              mag_d;

  assign dx_d  = DIFF_W'(in_data_i.point_x) - DIFF_W'(cx_q);
  assign dy_d  = DIFF_W'(in_data_i.point_y) - DIFF_W'(cy_q);
  assign ax_d  = dx_d[DIFF_W-1] ? DIFF_W'(-dx_d) : DIFF_W'(dx_d);
  assign ay_d  = dy_d[DIFF_W-1] ? DIFF_W'(-dy_d) : DIFF_W'(dy_d);
  assign mag_d = sp_q[31] ? 32'(-sp_q) : 32'(sp_q);

  logic                     a_valid_q;
  logic signed [DIFF_W-1:0] a_dx_q, a_dy_q;
  logic [DIFF_W-1:0]        a_ax_q, a_ay_q;
  logic [31:0]              a_mag_q;
  logic                     a_neg_q, a_zero_q;
  in_item_t                 a_item_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_dx_q   <= dx_d;
      a_dy_q   <= dy_d;
      a_ax_q   <= ax_d;
      a_ay_q   <= ay_d;
      a_mag_q  <= mag_d;
      a_neg_q  <= sp_q[31];
      a_zero_q <= (in_data_i.point_x == cx_q) && (in_data_i.point_y == cy_q);
      a_item_q <= in_data_i;
    end
  end

  // stage b: squares and turn numerator product
  logic              b_valid_q;
  logic [SUM_W-1:0]  b_sqx_q, b_sqy_q;
  sq_side_t          b_side_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      b_sqx_q       <= SUM_W'(a_ax_q) * SUM_W'(a_ax_q);
      b_sqy_q       <= SUM_W'(a_ay_q) * SUM_W'(a_ay_q);
      b_side_q.prod <= PROD_W'(a_mag_q) * PROD_W'(TURN_K);
      b_side_q.dx   <= a_dx_q;
      b_side_q.dy   <= a_dy_q;
      b_side_q.neg  <= a_neg_q;
      b_side_q.zero <= a_zero_q;
      b_side_q.item <= a_item_q;
    end
  end

  // stage c: sum of squares
  logic             c_valid_q;
  logic [SUM_W-1:0] c_sum_q;
  sq_side_t         c_side_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      c_sum_q  <= b_sqx_q + b_sqy_q;
      c_side_q <= b_side_q;
    end
  end

  // radius
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  spw_isqrt #(
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (c_valid_q),
    .op_i    (c_sum_q),
    .side_i  (c_side_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // stage d: rounded numerator
  logic              d_valid_q;
  logic [PROD_W-1:0] d_num_q;
  logic [ROOT_W-1:0] d_den_q;
  div_side_t         d_side_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      d_num_q       <= sq_side.prod + PROD_W'(sq_root[ROOT_W-1:1]);
      d_den_q       <= sq_root;
      d_side_q.dx   <= sq_side.dx;
      d_side_q.dy   <= sq_side.dy;
      d_side_q.neg  <= sq_side.neg;
      d_side_q.zero <= sq_side.zero;
      d_side_q.item <= sq_side.item;
    end
  end

  // turn = numerator / radius
  logic              dv_valid;
  logic [QUOT_W-1:0] dv_quot;
  div_side_t         dv_side;

  spw_div #(
    .SIDE_W ($bits(div_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (d_valid_q),
    .num_i   (d_num_q),
    .den_i   (d_den_q),
    .side_i  (d_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // stage e: signed turn, half-turn fold, cordic start values
  logic [31:0]              turn_d;
  logic                     fold_d;
  logic signed [CORD_W-1:0] xs_d, ys_d;

  assign turn_d = dv_side.neg ? 32'(-dv_quot) : dv_quot;
  assign fold_d = turn_d[31] ^ turn_d[30];
  assign xs_d   = CORD_W'(dv_side.dx) <<< 16;
  assign ys_d   = CORD_W'(dv_side.dy) <<< 16;

  logic                     e_valid_q;
  logic signed [CORD_W-1:0] e_x_q, e_y_q;
  logic signed [ANG_W-1:0]  e_z_q;
  cor_side_t                e_side_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      e_x_q         <= fold_d ? -xs_d : xs_d;
      e_y_q         <= fold_d ? -ys_d : ys_d;
      e_z_q         <= ANG_W'($signed({turn_d[31] ^ fold_d, turn_d[30:0]}));
      e_side_q.zero <= dv_side.zero;
      e_side_q.hout <= dv_side.zero ? dv_side.item.handle_angle
                                    : dv_side.item.handle_angle + turn_d;
      e_side_q.item <= dv_side.item;
    end
  end

  // rotation
  logic                     co_valid;
  logic signed [CORD_W-1:0] co_x, co_y;
  cor_side_t                co_side;

  spw_cordic #(
    .SIDE_W ($bits(cor_side_t))
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (e_valid_q),
    .x_i     (e_x_q),
    .y_i     (e_y_q),
    .z_i     (e_z_q),
    .side_i  (e_side_q),
    .valid_o (co_valid),
    .x_o     (co_x),
    .y_o     (co_y),
    .side_o  (co_side)
  );

  // stage f: magnitudes for the scale multiply
  logic signed [CORD_W-1:0] co_xa, co_ya;

  assign co_xa = co_x[CORD_W-1] ? -co_x : co_x;
  assign co_ya = co_y[CORD_W-1] ? -co_y : co_y;

  logic             f_valid_q;
  logic [MAG_W-1:0] f_mx_q, f_my_q;
  logic             f_nx_q, f_ny_q;
  cor_side_t        f_side_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      f_mx_q   <= MAG_W'(co_xa);
      f_my_q   <= MAG_W'(co_ya);
      f_nx_q   <= co_x[CORD_W-1];
      f_ny_q   <= co_y[CORD_W-1];
      f_side_q <= co_side;
    end
  end

  // stage g: partial products
  logic            g_valid_q;
  logic [63:0]     g_lox_q, g_loy_q;
  logic [HI_W-1:0] g_hix_q, g_hiy_q;
  logic            g_nx_q, g_ny_q;
  cor_side_t       g_side_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      g_lox_q  <= 64'(f_mx_q[31:0]) * 64'(SCALE_Q32);
      g_loy_q  <= 64'(f_my_q[31:0]) * 64'(SCALE_Q32);
      g_hix_q  <= HI_W'(f_mx_q[MAG_W-1:32]) * HI_W'(SCALE_Q32);
      g_hiy_q  <= HI_W'(f_my_q[MAG_W-1:32]) * HI_W'(SCALE_Q32);
      g_nx_q   <= f_nx_q;
      g_ny_q   <= f_ny_q;
      g_side_q <= f_side_q;
    end
  end

  // stage h: combine, round half away from zero, restore sign
  logic [MID_W-1:0] midx_d, midy_d;
  logic signed [SCALED_W-1:0] qx_d, qy_d;

  assign midx_d = MID_W'(g_hix_q) + MID_W'(g_lox_q[63:32]) + MID_W'(32'h8000);
  assign midy_d = MID_W'(g_hiy_q) + MID_W'(g_loy_q[63:32]) + MID_W'(32'h8000);
  assign qx_d   = $signed({1'b0, midx_d[MID_W-1:16]});
  assign qy_d   = $signed({1'b0, midy_d[MID_W-1:16]});

  logic                       h_valid_q;
  logic signed [SCALED_W-1:0] h_sx_q, h_sy_q;
  cor_side_t                  h_side_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      h_sx_q   <= g_nx_q ? -qx_d : qx_d;
      h_sy_q   <= g_ny_q ? -qy_d : qy_d;
      h_side_q <= g_side_q;
    end
  end

  // stage i: add center, saturate, pass-through for a point at the center
  logic signed [SAT_W-1:0] sumx_d, sumy_d;
  logic signed [31:0]      satx_d, saty_d;

  assign sumx_d = SAT_W'(cx_q) + SAT_W'(h_sx_q);
  assign sumy_d = SAT_W'(cy_q) + SAT_W'(h_sy_q);

  always_comb begin
    if (sumx_d > SAT_W'(32'sh7fffffff))       satx_d = 32'sh7fffffff;
    else if (sumx_d < -SAT_W'(33'sh80000000)) satx_d = 32'sh80000000;
    else                                      satx_d = sumx_d[31:0];
    if (sumy_d > SAT_W'(32'sh7fffffff))       saty_d = 32'sh7fffffff;
    else if (sumy_d < -SAT_W'(33'sh80000000)) saty_d = 32'sh80000000;
    else                                      saty_d = sumy_d[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      t_q.new_x            <= h_side_q.zero ? h_side_q.item.point_x : satx_d;
      t_q.new_y            <= h_side_q.zero ? h_side_q.item.point_y : saty_d;
      t_q.new_handle_angle <= h_side_q.hout;
      t_q.last_node_out    <= h_side_q.item.last_node;
    end
  end

  // valid bits of the top-level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
      h_valid_q <= 1'b0;
      t_valid_q <= 1'b0;
    end else if (pipe_en) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= sq_valid;
      e_valid_q <= dv_valid;
      f_valid_q <= co_valid;
      g_valid_q <= f_valid_q;
      h_valid_q <= g_valid_q;
      t_valid_q <= h_valid_q;
    end
  end

  // output register and skid control
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= t_valid_q;
      end
    end else if (pipe_en && t_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : t_q;
    end else if (pipe_en && t_valid_q) begin
      skid_q <= t_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a filled skid register always sits behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // a frozen pipe keeps its entry stage
  a_frozen_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(a_valid_q))
    else $error("entry stage moved while pipe frozen");

  // a taken result is replaced by the skid contents
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && skid_valid_q) |=> (out_valid_q && !skid_valid_q))
    else $error("skid register did not drain into output");

endmodule

// ===== hdl/spw_isqrt.sv =====
// swirl point warp: pipelined integer square root, one root bit per stage
// depends on spw_pkg
module spw_isqrt import spw_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SUM_W-1:0]  op_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned STEPS = ROOT_W;

  logic              vld_q  [STEPS];
  logic [SUM_W-1:0]  op_q   [STEPS];
  logic [SUM_W-1:0]  op_d   [STEPS];
  logic [REM_W-1:0]  rem_q  [STEPS];
  logic [REM_W-1:0]  rem_d  [STEPS];
  logic [ROOT_W-1:0] root_q [STEPS];
  logic [ROOT_W-1:0] root_d [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];
  logic [SIDE_W-1:0] side_d [STEPS];
  logic              vld_d  [STEPS];

  // one restoring step per stage, two operand bits from the top
  always_comb begin
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [SUM_W-1:0]  op_p;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    for (int k = 0; k < STEPS; k++) begin
      if (k == 0) begin
        rem_p     = '0;
        root_p    = '0;
        op_p      = op_i;
        side_d[k] = side_i;
        vld_d[k]  = valid_i;
      end else begin
        rem_p     = rem_q[k-1];
        root_p    = root_q[k-1];
        op_p      = op_q[k-1];
        side_d[k] = side_q[k-1];
        vld_d[k]  = vld_q[k-1];
      end
      cur   = {rem_p, op_p[SUM_W-1 -: 2]};
      trial = (REM_W+2)'({root_p, 2'b01});
      if (cur >= trial) begin
        rem_d[k]  = REM_W'(cur - trial);
        root_d[k] = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = cur[REM_W-1:0];
        root_d[k] = {root_p[ROOT_W-2:0], 1'b0};
      end
      op_d[k] = {op_p[SUM_W-3:0], 2'b00};
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STEPS; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < STEPS; k++) vld_q[k] <= vld_d[k];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < STEPS; k++) begin
        op_q[k]   <= op_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign root_o  = root_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

// ===== hdl/spw_div.sv =====
// swirl point warp: pipelined restoring divider, one dividend bit per stage,
// keeps the low quotient bits; depends on spw_pkg
module spw_div import spw_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [PROD_W-1:0] num_i,
  input  logic [ROOT_W-1:0] den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUOT_W-1:0] quot_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned STEPS = PROD_W;

  logic              vld_q  [STEPS];
  logic              vld_d  [STEPS];
  logic [PROD_W-1:0] num_q  [STEPS];
  logic [PROD_W-1:0] num_d  [STEPS];
  logic [ROOT_W-1:0] den_q  [STEPS];
  logic [ROOT_W-1:0] den_d  [STEPS];
  logic [ROOT_W-1:0] rem_q  [STEPS];
  logic [ROOT_W-1:0] rem_d  [STEPS];
  logic [QUOT_W-1:0] quot_q [STEPS];
  logic [QUOT_W-1:0] quot_d [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];
  logic [SIDE_W-1:0] side_d [STEPS];

  // shift in one dividend bit, subtract divisor when it fits
  always_comb begin
    logic [ROOT_W-1:0] rem_p;
    logic [PROD_W-1:0] num_p;
    logic [QUOT_W-1:0] quot_p;
    logic [ROOT_W:0]   cur;
    for (int k = 0; k < STEPS; k++) begin
      if (k == 0) begin
        rem_p     = '0;
        num_p     = num_i;
        quot_p    = '0;
        den_d[k]  = den_i;
        side_d[k] = side_i;
        vld_d[k]  = valid_i;
      end else begin
        rem_p     = rem_q[k-1];
        num_p     = num_q[k-1];
        quot_p    = quot_q[k-1];
        den_d[k]  = den_q[k-1];
        side_d[k] = side_q[k-1];
        vld_d[k]  = vld_q[k-1];
      end
      cur = {rem_p, num_p[PROD_W-1]};
      if (cur >= {1'b0, den_d[k]}) begin
        rem_d[k]  = ROOT_W'(cur - {1'b0, den_d[k]});
        quot_d[k] = {quot_p[QUOT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = cur[ROOT_W-1:0];
        quot_d[k] = {quot_p[QUOT_W-2:0], 1'b0};
      end
      num_d[k] = {num_p[PROD_W-2:0], 1'b0};
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STEPS; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < STEPS; k++) vld_q[k] <= vld_d[k];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < STEPS; k++) begin
        num_q[k]  <= num_d[k];
        den_q[k]  <= den_d[k];
        rem_q[k]  <= rem_d[k];
        quot_q[k] <= quot_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign quot_o  = quot_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

// ===== hdl/spw_cordic.sv =====
// swirl point warp: pipelined rotation-mode cordic, one micro-rotation per stage
// depends on spw_pkg (arctangent table, widths)
module spw_cordic import spw_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [CORD_W-1:0] x_i,
  input  logic signed [CORD_W-1:0] y_i,
  input  logic signed [ANG_W-1:0]  z_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic signed [CORD_W-1:0] x_o,
  output logic signed [CORD_W-1:0] y_o,
  output logic [SIDE_W-1:0]        side_o
);

  logic                     vld_q  [CORDIC_N];
  logic                     vld_d  [CORDIC_N];
  logic signed [CORD_W-1:0] x_q    [CORDIC_N];
  logic signed [CORD_W-1:0] x_d    [CORDIC_N];
  logic signed [CORD_W-1:0] y_q    [CORDIC_N];
  logic signed [CORD_W-1:0] y_d    [CORDIC_N];
  logic signed [ANG_W-1:0]  z_q    [CORDIC_N];
  logic signed [ANG_W-1:0]  z_d    [CORDIC_N];
  logic [SIDE_W-1:0]        side_q [CORDIC_N];
  logic [SIDE_W-1:0]        side_d [CORDIC_N];

  // rotate toward zero residual angle, floor shifts
  always_comb begin
    logic signed [CORD_W-1:0] x_p;
    logic signed [CORD_W-1:0] y_p;
    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;
    logic signed [ANG_W-1:0]  z_p;
    logic signed [ANG_W-1:0]  at;
    for (int k = 0; k < CORDIC_N; k++) begin
      if (k == 0) begin
        x_p       = x_i;
        y_p       = y_i;
        z_p       = z_i;
        side_d[k] = side_i;
        vld_d[k]  = valid_i;
      end else begin
        x_p       = x_q[k-1];
        y_p       = y_q[k-1];
        z_p       = z_q[k-1];
        side_d[k] = side_q[k-1];
        vld_d[k]  = vld_q[k-1];
      end
      xs = x_p >>> k;
      ys = y_p >>> k;
      at = $signed(ANG_W'(atan_step(5'(k))));
      if (!z_p[ANG_W-1]) begin
        x_d[k] = x_p - ys;
        y_d[k] = y_p + xs;
        z_d[k] = z_p - at;
      end else begin
        x_d[k] = x_p + ys;
        y_d[k] = y_p - xs;
        z_d[k] = z_p + at;
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CORDIC_N; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < CORDIC_N; k++) vld_q[k] <= vld_d[k];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CORDIC_N; k++) begin
        x_q[k]    <= x_d[k];
        y_q[k]    <= y_d[k];
        z_q[k]    <= z_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o = vld_q[CORDIC_N-1];
  assign x_o     = x_q[CORDIC_N-1];
  assign y_o     = y_q[CORDIC_N-1];
  assign side_o  = side_q[CORDIC_N-1];

endmodule
